// File: sv/three_axis_rate_pid_unit_defines.svh
// Assertion macros shared by the rate PID unit.
`ifndef THREE_AXIS_RATE_PID_UNIT_DEFINES_SVH
`define THREE_AXIS_RATE_PID_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define TRPID_ASSERT_NOW(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Check that a condition in one cycle is followed by another in the next.
`define TRPID_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TRPID_ASSERT_NOW(lbl, prop, msg)
`define TRPID_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: sv/trpid_pkg.sv
// Types, constants and arithmetic helpers of the rate PID unit.
package trpid_pkg;

	// Stick deadband edges in microseconds
	localparam logic [11:0] DEADBAND_HIGH = 12'd1508;
	localparam logic [11:0] DEADBAND_LOW  = 12'd1492;

	// ceil(2^18 / 3): exact reciprocal of three for magnitudes below 2^17
	localparam logic [16:0] RECIP3       = 17'd87382;
	localparam int          RECIP3_SHIFT = 18;

	// Axis codes
	localparam logic [1:0] AXIS_ROLL  = 2'd0;
	localparam logic [1:0] AXIS_PITCH = 2'd1;
	localparam logic [1:0] AXIS_YAW   = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_P_RP    = 3'd0;
	localparam logic [2:0] REG_I_RP    = 3'd1;
	localparam logic [2:0] REG_D_RP    = 3'd2;
	localparam logic [2:0] REG_LIM_RP  = 3'd3;
	localparam logic [2:0] REG_P_YAW   = 3'd4;
	localparam logic [2:0] REG_I_YAW   = 3'd5;
	localparam logic [2:0] REG_D_YAW   = 3'd6;
	localparam logic [2:0] REG_LIM_YAW = 3'd7;

	// Gain and limit set of one axis group
	typedef struct packed {
		logic [15:0] kp;
		logic [15:0] ki;
		logic [15:0] kd;
		logic [14:0] limit;
	} trpid_gains_t;

	typedef struct packed {
		trpid_gains_t rp;
		trpid_gains_t yaw;
	} trpid_cfg_t;

	// Saturated errors of one control period, index is the axis code
	typedef logic [2:0][15:0] trpid_err_vec_t;

	// Head of the error queue as seen by the back end
	typedef struct packed {
		logic           valid;
		trpid_err_vec_t errs;
	} trpid_q_head_t;

	// Q24.12 to Q24.4, round half up
	function automatic logic signed [27:0] round_q12(input logic signed [35:0] x);
		logic signed [35:0] t;
		t = x + 36'sd128;
		return t[35:8];
	endfunction

	// Clamp to plus or minus the limit
	function automatic logic signed [15:0] clamp_sym(input logic signed [27:0] v,
		input logic [14:0] lim);
		logic signed [27:0] hi;
		logic signed [27:0] lo;
		logic signed [27:0] r;
		hi = $signed({13'b0, lim});
		lo = -hi;
		if (v > hi) begin
			r = hi;
		end else if (v < lo) begin
			r = lo;
		end else begin
			r = v;
		end
		return r[15:0];
	endfunction

endpackage

// File: sv/trpid_in_if.sv
// Input channel: sticks, level corrections and measured rates of one period.
interface trpid_in_if;
	logic               valid;
	logic               ready;
	logic [11:0]        roll_stick;
	logic [11:0]        pitch_stick;
	logic [11:0]        yaw_stick;
	logic signed [15:0] roll_level;
	logic signed [15:0] pitch_level;
	logic signed [15:0] roll_rate;
	logic signed [15:0] pitch_rate;
	logic signed [15:0] yaw_rate;

	modport source (
		output valid, roll_stick, pitch_stick, yaw_stick, roll_level, pitch_level,
		output roll_rate, pitch_rate, yaw_rate,
		input  ready
	);
	modport sink (
		input  valid, roll_stick, pitch_stick, yaw_stick, roll_level, pitch_level,
		input  roll_rate, pitch_rate, yaw_rate,
		output ready
	);
endinterface

// File: sv/trpid_out_if.sv
// Output channel: the three clamped PID drives of one period.
interface trpid_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] roll_drive;
	logic signed [15:0] pitch_drive;
	logic signed [15:0] yaw_drive;

	modport source (
		output valid, roll_drive, pitch_drive, yaw_drive,
		input  ready
	);
	modport sink (
		input  valid, roll_drive, pitch_drive, yaw_drive,
		output ready
	);
endinterface

// File: sv/trpid_front.sv
// Front end: setpoints from sticks, divide by three, saturated rate errors.
module trpid_front (
	input  logic                      clk,
	input  logic                      arst_n,
	trpid_in_if.sink                  in_ch,
	input  logic                      q_full,
	output logic                      q_push,
	output trpid_pkg::trpid_err_vec_t q_data
);
	import trpid_pkg::*;

	logic                     en_s1;
	logic                     en_s2;
	logic                     v_s1;
	logic                     v_s2;
	logic [2:0][11:0]         stick;
	logic [2:0][15:0]         level;
	logic [2:0][15:0]         rate;
	logic [2:0][16:0]         mag;
	logic [2:0]               neg;
	logic [2:0][16:0]         mag_s1;
	logic [2:0]               neg_s1;
	logic [2:0][15:0]         rate_s1;
	logic [2:0][15:0]         quot_s2;
	logic [2:0]               neg_s2;
	logic [2:0][15:0]         rate_s2;

	// Stall a stage only when its successor cannot take the transfer
	assign en_s2       = !v_s2 || !q_full;
	assign en_s1       = !v_s1 || en_s2;
	assign in_ch.ready = en_s1;
	assign q_push      = v_s2 && !q_full;

	assign stick = {in_ch.yaw_stick, in_ch.pitch_stick, in_ch.roll_stick};
	assign level = {16'd0, in_ch.pitch_level, in_ch.roll_level};
	assign rate  = {in_ch.yaw_rate, in_ch.pitch_rate, in_ch.roll_rate};

	// Deadband offset, level correction and magnitude for the divider
	always_comb begin
		logic signed [16:0] off;
		logic signed [17:0] num;
		for (int a = 0; a < 3; a++) begin
			if (stick[a] > DEADBAND_HIGH) begin
				off = $signed({1'b0, stick[a] - DEADBAND_HIGH, 4'b0});
			end else if (stick[a] < DEADBAND_LOW) begin
				off = $signed({1'b1, stick[a] - DEADBAND_LOW, 4'b0});
			end else begin
				off = '0;
			end
			num    = {off[16], off} - {{2{level[a][15]}}, level[a]};
			neg[a] = num[17];
			mag[a] = num[17] ? 17'(-num) : num[16:0];
		end
	end

	// Stage 1: hold magnitude, sign and measured rate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mag_s1  <= mag;
			neg_s1  <= neg;
			rate_s1 <= rate;
		end
	end

	// Stage 2: divide by three through the reciprocal
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		logic [33:0] prod;
		if (en_s2) begin
			for (int a = 0; a < 3; a++) begin
				prod        = mag_s1[a] * RECIP3;
				quot_s2[a] <= prod[RECIP3_SHIFT +: 16];
			end
			neg_s2  <= neg_s1;
			rate_s2 <= rate_s1;
		end
	end

	// Error = measured - setpoint, saturated to 16 bits
	always_comb begin
		logic signed [16:0] sp;
		logic signed [17:0] e;
		for (int a = 0; a < 3; a++) begin
			sp = neg_s2[a] ? -$signed({1'b0, quot_s2[a]}) : $signed({1'b0, quot_s2[a]});
			e  = {{2{rate_s2[a][15]}}, rate_s2[a]} - {sp[16], sp};
			if (e > 18'sd32767) begin
				q_data[a] = 16'h7FFF;
			end else if (e < -18'sd32768) begin
				q_data[a] = 16'h8000;
			end else begin
				q_data[a] = e[15:0];
			end
		end
	end

endmodule

// File: sv/trpid_queue.sv
// Two-entry queue of error sets between the front and back ends.
module trpid_queue (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  trpid_pkg::trpid_err_vec_t push_data,
	output logic                      full,
	input  logic                      pop,
	output trpid_pkg::trpid_q_head_t  head
);
	import trpid_pkg::*;

	trpid_err_vec_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full       = count_q == 2'd2;
	assign head.valid = count_q != 2'd0;
	assign head.errs  = entry_q[rd_ptr_q];

	// Store pushed sets
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// File: sv/trpid_back.sv
// Back end: per-axis PID sequencer on one shared multiplier, output register.
module trpid_back (
	input  logic                     clk,
	input  logic                     arst_n,
	input  trpid_pkg::trpid_cfg_t    cfg,
	input  trpid_pkg::trpid_q_head_t head,
	output logic                     q_pop,
	trpid_out_if.source              out_ch
);
	import trpid_pkg::*;
	`include "three_axis_rate_pid_unit_defines.svh"

	// Sequencer steps within one axis
	localparam logic [2:0] STEP_IMUL  = 3'd0;
	localparam logic [2:0] STEP_INTEG = 3'd1;
	localparam logic [2:0] STEP_ACC   = 3'd2;
	localparam logic [2:0] STEP_SUM   = 3'd3;
	localparam logic [2:0] STEP_OUT   = 3'd4;

	logic                busy_q;
	logic [1:0]          axis_q;
	logic [2:0]          step_q;
	trpid_err_vec_t      err_q;
	logic signed [15:0]  integ_q [3];
	logic signed [15:0]  prev_q  [3];
	logic signed [15:0]  res_q   [2];
	logic signed [33:0]  prod_q;
	logic signed [35:0]  acc_q;
	logic                out_v_q;
	logic signed [15:0]  drive_q [3];

	trpid_gains_t        g;
	logic signed [15:0]  err;
	logic signed [16:0]  derr;
	logic signed [16:0]  mul_a;
	logic [15:0]         mul_g;
	logic signed [33:0]  prod;
	logic signed [15:0]  integ_new;
	logic signed [15:0]  res;
	logic                out_free;
	logic                last_axis;
	logic                finish;

	assign g         = (axis_q == AXIS_YAW) ? cfg.yaw : cfg.rp;
	assign err       = err_q[axis_q];
	assign derr      = {err[15], err} - {prev_q[axis_q][15], prev_q[axis_q]};
	assign out_free  = !out_v_q || out_ch.ready;
	assign last_axis = axis_q == AXIS_YAW;
	assign finish    = busy_q && step_q == STEP_OUT && last_axis && out_free;
	assign q_pop     = head.valid && !busy_q;

	// Shared multiplier: gain times error or error difference
	always_comb begin
		mul_a = {err[15], err};
		mul_g = g.ki;
		unique case (step_q)
			STEP_IMUL: begin
				mul_g = g.ki;
			end
			STEP_INTEG: begin
				mul_g = g.kp;
			end
			STEP_ACC: begin
				mul_a = derr;
				mul_g = g.kd;
			end
			default: begin
				mul_g = g.ki;
			end
		endcase
	end

	assign prod = mul_a * $signed({1'b0, mul_g});

	assign integ_new = clamp_sym(
		28'(integ_q[axis_q]) + round_q12({{2{prod_q[33]}}, prod_q}), g.limit);
	assign res = clamp_sym(round_q12(acc_q), g.limit);

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			axis_q <= AXIS_ROLL;
			step_q <= STEP_IMUL;
		end else if (!busy_q) begin
			if (head.valid) begin
				busy_q <= 1'b1;
				axis_q <= AXIS_ROLL;
				step_q <= STEP_IMUL;
			end
		end else begin
			unique case (step_q)
				STEP_OUT: begin
					if (!last_axis) begin
						axis_q <= axis_q + 2'd1;
						step_q <= STEP_IMUL;
					end else if (out_free) begin
						busy_q <= 1'b0;
						step_q <= STEP_IMUL;
					end
				end
				STEP_IMUL, STEP_INTEG, STEP_ACC, STEP_SUM: begin
					step_q <= step_q + 3'd1;
				end
				default: begin
					step_q <= STEP_IMUL;
				end
			endcase
		end
	end

	// Controller state: integrators and previous errors
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < 3; a++) begin
				integ_q[a] <= '0;
				prev_q[a]  <= '0;
			end
		end else if (busy_q) begin
			if (step_q == STEP_INTEG) begin
				integ_q[axis_q] <= integ_new;
			end
			if (step_q == STEP_OUT && (!last_axis || out_free)) begin
				prev_q[axis_q] <= err;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (q_pop) begin
			err_q <= head.errs;
		end
		if (busy_q) begin
			prod_q <= prod;
			unique case (step_q)
				STEP_ACC: begin
					acc_q <= {{2{prod_q[33]}}, prod_q}
						+ {{12{integ_q[axis_q][15]}}, integ_q[axis_q], 8'b0};
				end
				STEP_SUM: begin
					acc_q <= acc_q + {{2{prod_q[33]}}, prod_q};
				end
				STEP_OUT: begin
					if (!last_axis) begin
						res_q[axis_q[0]] <= res;
					end
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
		if (finish) begin
			drive_q[AXIS_ROLL]  <= res_q[0];
			drive_q[AXIS_PITCH] <= res_q[1];
			drive_q[AXIS_YAW]   <= res;
		end
	end

	// Output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (finish) begin
			out_v_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_v_q <= 1'b0;
		end
	end

	assign out_ch.valid       = out_v_q;
	assign out_ch.roll_drive  = drive_q[AXIS_ROLL];
	assign out_ch.pitch_drive = drive_q[AXIS_PITCH];
	assign out_ch.yaw_drive   = drive_q[AXIS_YAW];

	`TRPID_ASSERT_NEXT(a_pop_starts_roll, q_pop, busy_q && axis_q == AXIS_ROLL && step_q == STEP_IMUL, "pop did not start a roll pass")
	`TRPID_ASSERT_NOW(a_seq_range, busy_q |-> (step_q <= STEP_OUT && axis_q <= AXIS_YAW), "sequencer left its range")
	`TRPID_ASSERT_NOW(a_result_from_yaw, $rose(out_v_q) |-> $past(busy_q && last_axis && step_q == STEP_OUT), "result shown without a finished yaw pass")
	`TRPID_ASSERT_NEXT(a_finish_frees, finish, !busy_q && out_v_q, "finish did not free the sequencer")

endmodule

// File: sv/three_axis_rate_pid_unit.sv
// Top level of the three-axis rate PID unit: configuration registers and wiring.
//
// One input transfer carries a control period's sticks, level corrections and
// measured rates; one output transfer carries the three clamped drives. The front
// end (two register stages) turns sticks into setpoints, divides by three with a
// reciprocal multiply and forms saturated errors, then hands them through a
// two-entry queue. The back end runs one shared 17x17 multiplier through five steps
// per axis, roll, pitch then yaw, and takes the next error set from the queue only
// once it is idle again, so it starts a new item only after the last one is finished;
// input transfers are taken every cycle until the front stages and the queue are full.
// A finished result waits in an output register while the next item is already in
// work. Write configuration with cfg_we high only while no item is in flight, as the
// back end reads the gains directly; registers take the low bits of cfg_data.
module three_axis_rate_pid_unit (
	input  logic        clk,
	input  logic        arst_n,
	trpid_in_if.sink    in_ch,
	trpid_out_if.source out_ch,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import trpid_pkg::*;

	trpid_cfg_t     cfg_q;
	logic           q_full;
	logic           q_push;
	trpid_err_vec_t q_data;
	logic           q_pop;
	trpid_q_head_t  q_head;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rp.kp     <= 16'd333;
			cfg_q.rp.ki     <= 16'd10;
			cfg_q.rp.kd     <= 16'd4608;
			cfg_q.rp.limit  <= 15'd6400;
			cfg_q.yaw.kp    <= 16'd1024;
			cfg_q.yaw.ki    <= 16'd5;
			cfg_q.yaw.kd    <= 16'd0;
			cfg_q.yaw.limit <= 15'd6400;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_P_RP:    cfg_q.rp.kp     <= cfg_data;
				REG_I_RP:    cfg_q.rp.ki     <= cfg_data;
				REG_D_RP:    cfg_q.rp.kd     <= cfg_data;
				REG_LIM_RP:  cfg_q.rp.limit  <= cfg_data[14:0];
				REG_P_YAW:   cfg_q.yaw.kp    <= cfg_data;
				REG_I_YAW:   cfg_q.yaw.ki    <= cfg_data;
				REG_D_YAW:   cfg_q.yaw.kd    <= cfg_data;
				REG_LIM_YAW: cfg_q.yaw.limit <= cfg_data[14:0];
				default:     cfg_q           <= cfg_q;
			endcase
		end
	end

	trpid_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_data)
	);

	trpid_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head)
	);

	trpid_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.head   (q_head),
		.q_pop  (q_pop),
		.out_ch (out_ch)
	);

endmodule
